[hdl/dedup_merge_two_lists_sorted_assert.svh]
// assertion macros used by the checker file
`ifndef DEDUP_MERGE_TWO_LISTS_SORTED_ASSERT_SVH
`define DEDUP_MERGE_TWO_LISTS_SORTED_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define DMTS_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("dmts assertion failed");

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define DMTS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("dmts assertion failed");

`endif

[hdl/dmts_pkg.sv]
// shared types and constants of the two-list merge block
`timescale 1ns / 1ps

package dmts_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int KEY_W           = 24;
	localparam int TAG_W           = 32;
	localparam int POS_W           = 7;

	// request commands
	localparam logic [1:0] CMD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	// membership status codes
	localparam logic [1:0] STAT_FIRST  = 2'd1;
	localparam logic [1:0] STAT_SECOND = 2'd2;
	localparam logic [1:0] STAT_BOTH   = 2'd3;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] student_key;
		logic [TAG_W-1:0] entry_tag;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [KEY_W-1:0] key_out;
		logic [TAG_W-1:0] tag_out;
		logic             in_first;
		logic             in_second;
		logic             final_entry;
		logic             dropped;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [1:0]       status;
	} cell_data_t;

	typedef struct packed {
		logic       valid;
		cell_data_t data;
	} entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_COMPARE,
		CELL_INSERT,
		CELL_MERGE,
		CELL_DRAIN
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		cell_data_t fresh;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_APPLY,
		ST_EMIT
	} state_t;

endpackage

[hdl/dmts_cell.sv]
// one cell of the sorted key chain
`timescale 1ns / 1ps

module dmts_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dmts_pkg::cell_ctrl_t ctrl,
	input  dmts_pkg::entry_t    left,
	input  logic                left_gt,
	input  dmts_pkg::entry_t    right,
	output dmts_pkg::entry_t    entry,
	output logic                eq,
	output logic                gt
);

	logic                 valid_q;
	dmts_pkg::cell_data_t data_q;
	logic                 eq_q;
	logic                 gt_q;
	logic                 take_new;

	// boundary of the insertion point: first cell that is empty or whose key lies above the new one
	assign take_new = gt_q & ~left_gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				dmts_pkg::CELL_INSERT: begin
					if (take_new) begin
						valid_q <= 1'b1;
					end else if (left_gt) begin
						valid_q <= left.valid;
					end
				end
				dmts_pkg::CELL_DRAIN: valid_q <= right.valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			dmts_pkg::CELL_INSERT: begin
				if (take_new) begin
					data_q <= ctrl.fresh;
				end else if (left_gt) begin
					data_q <= left.data;
				end
			end
			dmts_pkg::CELL_MERGE: begin
				if (eq_q && data_q.status != dmts_pkg::STAT_SECOND) begin
					data_q.status <= dmts_pkg::STAT_BOTH;
				end
			end
			dmts_pkg::CELL_DRAIN: data_q <= right.data;
			default: data_q <= data_q;
		endcase
	end

	// compare flags, taken once per entry request
	always_ff @(posedge clk) begin
		if (ctrl.op == dmts_pkg::CELL_COMPARE) begin
			eq_q <= valid_q & (data_q.key == ctrl.fresh.key);
			gt_q <= ~valid_q | (data_q.key > ctrl.fresh.key);
		end
	end

	assign entry.valid = valid_q;
	assign entry.data  = data_q;
	assign eq          = eq_q;
	assign gt          = gt_q;

endmodule

[hdl/dedup_merge_two_lists_sorted.sv]
// top level of the two-list merge with duplicate removal and membership flags
`timescale 1ns / 1ps

// a request is taken when start is high and busy is low. for each list entry, every
// cell of the chain first compares its stored key against the new key; then the chain
// either updates the matching cell (second-list hits only) or, for a new key, opens a
// gap and shifts the larger keys one cell to the right; a new key meeting a full table
// is dropped and sets the sticky overflow flag. the chain is therefore always in
// ascending key order. a finish request drains the chain through cell zero, one entry
// per cycle, keeping busy high until the last entry has left; results come out of a
// register loaded from cell zero, each for exactly one cycle under result_strobe, and
// the receiver has no means to hold them off. after a finish the table and the sticky
// overflow flag are clear. command three is taken and ignored.
module dedup_merge_two_lists_sorted #(
	parameter int MAX_ENTRIES = dmts_pkg::MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dmts_pkg::req_t    request,
	output dmts_pkg::result_t result,
	output logic              result_strobe
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int POS_W = dmts_pkg::POS_W;

	dmts_pkg::state_t     state_q;
	dmts_pkg::state_t     state_nxt;
	dmts_pkg::req_t       req_q;
	dmts_pkg::cell_ctrl_t ctrl;
	dmts_pkg::cell_op_t   chain_op;
	logic [CNT_W-1:0]     entry_count_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 overflow_q;
	logic                 strobe_q;
	dmts_pkg::result_t    result_q;

	dmts_pkg::entry_t     entries [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] eq_vec;
	logic [MAX_ENTRIES-1:0] gt_vec;

	logic accept;
	logic any_eq;
	logic full;
	logic drain_done;

	assign accept     = start & ~busy;
	assign any_eq     = |eq_vec;
	assign full       = (entry_count_q == CNT_W'(MAX_ENTRIES));
	// the last entry leaves cell zero this cycle, or there was nothing to emit
	assign drain_done = ~entries[0].valid | ~entries[1].valid;

	// the new entry as it would be stored
	assign ctrl.fresh.key    = req_q.student_key;
	assign ctrl.fresh.tag    = req_q.entry_tag;
	assign ctrl.fresh.status = (req_q.command == dmts_pkg::CMD_SECOND) ?
		dmts_pkg::STAT_SECOND : dmts_pkg::STAT_FIRST;
	assign ctrl.op           = chain_op;

	// chain of cells, each fed by its neighbours
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		dmts_pkg::entry_t left;
		dmts_pkg::entry_t right;
		logic             left_gt;

		if (i == 0) begin : g_head
			assign left    = '0;
			assign left_gt = 1'b0;
		end else begin : g_body
			assign left    = entries[i-1];
			assign left_gt = gt_vec[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign right = '0;
		end else begin : g_next
			assign right = entries[i+1];
		end

		dmts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    (left),
			.left_gt (left_gt),
			.right   (right),
			.entry   (entries[i]),
			.eq      (eq_vec[i]),
			.gt      (gt_vec[i])
		);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dmts_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (request.command) inside
						dmts_pkg::CMD_FIRST, dmts_pkg::CMD_SECOND: state_nxt = dmts_pkg::ST_LOOKUP;
						dmts_pkg::CMD_FINISH: state_nxt = dmts_pkg::ST_EMIT;
						default: state_nxt = dmts_pkg::ST_IDLE;
					endcase
				end
			end
			dmts_pkg::ST_LOOKUP: state_nxt = dmts_pkg::ST_APPLY;
			dmts_pkg::ST_APPLY:  state_nxt = dmts_pkg::ST_IDLE;
			dmts_pkg::ST_EMIT: begin
				if (drain_done) begin
					state_nxt = dmts_pkg::ST_IDLE;
				end
			end
			default: state_nxt = dmts_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: chain operation and busy
	always_comb begin
		chain_op = dmts_pkg::CELL_HOLD;
		busy     = 1'b1;
		unique case (state_q)
			dmts_pkg::ST_IDLE:   busy = 1'b0;
			dmts_pkg::ST_LOOKUP: chain_op = dmts_pkg::CELL_COMPARE;
			dmts_pkg::ST_APPLY: begin
				if (any_eq) begin
					// known key: only a second-list hit can change the status
					if (req_q.command == dmts_pkg::CMD_SECOND) begin
						chain_op = dmts_pkg::CELL_MERGE;
					end
				end else if (!full) begin
					chain_op = dmts_pkg::CELL_INSERT;
				end
			end
			dmts_pkg::ST_EMIT: chain_op = dmts_pkg::CELL_DRAIN;
			default: chain_op = dmts_pkg::CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmts_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
	end

	// fill count, rank counter and sticky overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			pos_q         <= '0;
			overflow_q    <= 1'b0;
		end else if (state_q == dmts_pkg::ST_APPLY && !any_eq) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end
		end else if (state_q == dmts_pkg::ST_EMIT) begin
			if (drain_done) begin
				entry_count_q <= '0;
				pos_q         <= '0;
				overflow_q    <= 1'b0;
			end else begin
				pos_q <= pos_q + CNT_W'(1);
			end
		end
	end

	// result register, loaded from cell zero while draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == dmts_pkg::ST_EMIT) & entries[0].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dmts_pkg::ST_EMIT) begin
			result_q.position    <= POS_W'(pos_q) + POS_W'(1);
			result_q.key_out     <= entries[0].data.key;
			result_q.tag_out     <= entries[0].data.tag;
			result_q.in_first    <= (entries[0].data.status == dmts_pkg::STAT_FIRST) ||
				(entries[0].data.status == dmts_pkg::STAT_BOTH);
			result_q.in_second   <= (entries[0].data.status == dmts_pkg::STAT_SECOND) ||
				(entries[0].data.status == dmts_pkg::STAT_BOTH);
			result_q.final_entry <= ~entries[1].valid;
			result_q.dropped     <= overflow_q;
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

[hdl/dmts_checker.sv]
// port-level checks of the two-list merge block and their binding
`timescale 1ns / 1ps
`include "dedup_merge_two_lists_sorted_assert.svh"

module dmts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input dmts_pkg::req_t    request,
	input dmts_pkg::result_t result,
	input logic              result_strobe
);

	logic entry_req;
	logic more_to_come;

	assign entry_req = start && !busy &&
		(request.command == dmts_pkg::CMD_FIRST || request.command == dmts_pkg::CMD_SECOND);
	assign more_to_come = result_strobe && !result.final_entry;

	// an entry request keeps the block busy for its compare step
	`DMTS_ASSERT_NEXT(a_entry_busy, entry_req, busy)
	// results of one run come back to back until the final one
	`DMTS_ASSERT_NEXT(a_run_contiguous, more_to_come, result_strobe)
	// ranks climb by one within a run
	`DMTS_ASSERT_NEXT(a_rank_step, more_to_come,
		result.position == $past(result.position) + 7'd1)
	// every emitted entry belongs to at least one list
	`DMTS_ASSERT_SAME(a_member, result_strobe, result.in_first || result.in_second)

endmodule

bind dedup_merge_two_lists_sorted dmts_checker u_dmts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.request       (request),
	.result        (result),
	.result_strobe (result_strobe)
);

[bench/testbench.sv]
// self-checking testbench for the two-list merge with duplicate removal
`timescale 1ns / 1ps

module testbench;

	import dmts_pkg::*;

	// command three is taken by the block and ignored
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// run length: enough for every finish draining a full table many times over
	localparam int CYCLE_LIMIT = 200000;
	localparam int TARGET_ITEMS = 310;
	// room left before a large list pair may still be started
	localparam int LARGE_ROOM = 110;
	// drain of a full table plus the registered result, with margin
	localparam int DRAIN_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	// tracks the unique-key table and the sorted rows each finish must produce
	class union_table;
		logic [KEY_W-1:0] keys [MAX_ENTRIES_DEF];
		logic [TAG_W-1:0] tags [MAX_ENTRIES_DEF];
		logic [1:0]       stats [MAX_ENTRIES_DEF];
		int               count;
		bit               overflow;
		result_t          pending_rows [$];
		int               errors;
		int               requests;
		int               rows_checked;
		int               finishes;
		int               overflow_finishes;

		function int find(logic [KEY_W-1:0] k);
			for (int i = 0; i < count; i++)
				if (keys[i] == k)
					return i;
			return -1;
		endfunction

		// a new key meeting a full table is dropped and marks the run
		function void add(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic [1:0] s);
			if (count >= MAX_ENTRIES_DEF) begin
				overflow = 1'b1;
				return;
			end
			keys[count]  = k;
			tags[count]  = t;
			stats[count] = s;
			count++;
		endfunction

		// updates the table for one accepted request and queues any rows it yields
		function void take_request(req_t r);
			int      idx;
			int      best;
			int      tmp;
			int      order [MAX_ENTRIES_DEF];
			result_t row;
			requests++;
			case (r.command)
				CMD_FIRST: begin
					// a repeated first-list key leaves everything alone
					if (find(r.student_key) < 0)
						add(r.student_key, r.entry_tag, STAT_FIRST);
				end
				CMD_SECOND: begin
					idx = find(r.student_key);
					if (idx < 0)
						add(r.student_key, r.entry_tag, STAT_SECOND);
					else if (stats[idx] != STAT_SECOND)
						stats[idx] = STAT_BOTH;
				end
				CMD_FINISH: begin
					finishes++;
					if (overflow)
						overflow_finishes++;
					for (int i = 0; i < count; i++)
						order[i] = i;
					// selection sort on key, keys are unique
					for (int i = 0; i + 1 < count; i++) begin
						best = i;
						for (int j = i + 1; j < count; j++)
							if (keys[order[j]] < keys[order[best]])
								best = j;
						tmp         = order[i];
						order[i]    = order[best];
						order[best] = tmp;
					end
					for (int i = 0; i < count; i++) begin
						row.position    = POS_W'(i + 1);
						row.key_out     = keys[order[i]];
						row.tag_out     = tags[order[i]];
						row.in_first    = stats[order[i]] == STAT_FIRST ||
						                  stats[order[i]] == STAT_BOTH;
						row.in_second   = stats[order[i]] == STAT_SECOND ||
						                  stats[order[i]] == STAT_BOTH;
						row.final_entry = i == count - 1;
						row.dropped     = overflow;
						pending_rows.push_back(row);
					end
					count    = 0;
					overflow = 1'b0;
				end
				default: ;
			endcase
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		endtask

		// compares a strobed row with the oldest one still owed
		task check_row(result_t got);
			result_t want;
			if (pending_rows.size() == 0) begin
				report("row with nothing owed", got.key_out, 0);
				return;
			end
			want = pending_rows.pop_front();
			rows_checked++;
			if (got.position !== want.position)
				report("position", got.position, want.position);
			if (got.key_out !== want.key_out)
				report("key_out", got.key_out, want.key_out);
			if (got.tag_out !== want.tag_out)
				report("tag_out", got.tag_out, want.tag_out);
			if (got.in_first !== want.in_first)
				report("in_first", got.in_first, want.in_first);
			if (got.in_second !== want.in_second)
				report("in_second", got.in_second, want.in_second);
			if (got.final_entry !== want.final_entry)
				report("final_entry", got.final_entry, want.final_entry);
			if (got.dropped !== want.dropped)
				report("dropped", got.dropped, want.dropped);
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	req_t    request;
	result_t result;
	logic    result_strobe;

	union_table book;
	int         items_sent;
	int         burst_left;
	int         cycle_count;

	dedup_merge_two_lists_sorted dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result       (result),
		.result_strobe(result_strobe)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sample at the rising edge: take accepted requests, check strobed rows
	// the receiver has no way to stall, so there is no back-pressure to model
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				book.take_request(request);
			if (result_strobe)
				book.check_row(result);
		end
	end

	// watchdog: a hung block or lost rows end the run here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// sender works in bursts; between bursts start drops for a random gap
	task automatic send_request(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 8);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		// held until the block takes it
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_entry(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
	                          input logic [TAG_W-1:0] t);
		req_t r;
		r.command     = cmd;
		r.student_key = k;
		r.entry_tag   = t;
		send_request(r);
	endtask

	// drop start and hold off until every owed row has come out
	task automatic drain_rows();
		@(negedge clk);
		start <= 1'b0;
		while (book.pending_rows.size() > 0)
			@(posedge clk);
	endtask

	// mostly in 0 to 9999999, now and then any 24-bit value
	function automatic logic [KEY_W-1:0] fresh_key();
		if ($urandom_range(0, 7) == 0)
			return KEY_W'($urandom);
		return KEY_W'($urandom_range(0, 9999999));
	endfunction

	// reuse a key already sent in this list pair with the given odds, else a new one
	function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] seen [$],
	                                              input int reuse_pct);
		if (seen.size() > 0 && $urandom_range(0, 99) < reuse_pct)
			return seen[$urandom_range(0, seen.size() - 1)];
		return fresh_key();
	endfunction

	// one well-formed pair of lists and a finish; noisy pairs slip in late
	// first-list entries and ignored commands among the second list
	task automatic run_lists(input int n_first, input int n_second, input bit noisy);
		logic [KEY_W-1:0] seen [$];
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n_first; i++) begin
			k = pick_key(seen, 25);
			seen.push_back(k);
			send_entry(CMD_FIRST, k, $urandom);
		end
		for (int i = 0; i < n_second; i++) begin
			k = pick_key(seen, 60);
			seen.push_back(k);
			send_entry(CMD_SECOND, k, $urandom);
			if (noisy && $urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 1) == 0)
					send_entry(CMD_FIRST, pick_key(seen, 50), $urandom);
				else
					send_entry(CMD_SPARE, fresh_key(), $urandom);
			end
		end
		send_entry(CMD_FINISH, fresh_key(), $urandom);
	endtask

	// fills the table past its depth with distinct keys in shuffled order
	task automatic run_full_table();
		logic [KEY_W-1:0] slots [70];
		logic [KEY_W-1:0] tmp;
		int               j;
		for (int i = 0; i < 70; i++)
			slots[i] = KEY_W'(i * 200000 + $urandom_range(0, 199999));
		for (int i = 69; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = slots[i];
			slots[i] = slots[j];
			slots[j] = tmp;
		end
		for (int i = 0; i < 60; i++)
			send_entry(CMD_FIRST, slots[i], $urandom);
		// four fit, the rest are new keys meeting a full table
		for (int i = 60; i < 70; i++)
			send_entry(CMD_SECOND, slots[i], $urandom);
		// matches still update status on a full table, a dropped key stays dropped
		send_entry(CMD_SECOND, slots[3], $urandom);
		send_entry(CMD_SECOND, slots[10], $urandom);
		send_entry(CMD_FIRST, slots[66], $urandom);
		send_entry(CMD_FINISH, 24'd0, $urandom);
	endtask

	initial begin
		int waited;
		int n_first;
		int n_second;
		book       = new();
		items_sent = 0;
		burst_left = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty finish, field extremes, every duplicate rule
		send_entry(CMD_FINISH, 24'd0, 32'd0);
		send_entry(CMD_FIRST, 24'd0, 32'd0);
		send_entry(CMD_FIRST, 24'd9999999, 32'hffff_ffff);
		send_entry(CMD_FIRST, 24'hff_ffff, 32'ha5a5_a5a5);
		// repeated first-list key keeps its original tag
		send_entry(CMD_FIRST, 24'd0, 32'h1234_5678);
		send_entry(CMD_FIRST, 24'd500, 32'h0000_0500);
		// second-list hit on a first-only key becomes both
		send_entry(CMD_SECOND, 24'd500, 32'hdead_beef);
		// new second-list key, then a repeat that stays second-only
		send_entry(CMD_SECOND, 24'd777, 32'h0000_0777);
		send_entry(CMD_SECOND, 24'd777, 32'h1111_1111);
		send_entry(CMD_SECOND, 24'd9999999, 32'h2222_2222);
		send_entry(CMD_SECOND, 24'd9999999, 32'h3333_3333);
		// late first-list entries: existing second-only left alone, new one first-only
		send_entry(CMD_FIRST, 24'd777, 32'h4444_4444);
		send_entry(CMD_FIRST, 24'd42, 32'h0000_0042);
		send_entry(CMD_SPARE, 24'd1, 32'h5555_5555);
		send_entry(CMD_SECOND, 24'd123456, 32'h5a5a_5a5a);
		send_entry(CMD_FINISH, 24'hff_ffff, 32'hffff_ffff);
		// table must be clear again
		send_entry(CMD_FINISH, 24'd0, 32'd0);
		drain_rows();

		// overflow run, then wait for its rows
		run_full_table();
		drain_rows();

		// random list pairs, mostly small, now and then large enough to overflow
		while (items_sent < TARGET_ITEMS) begin
			if (TARGET_ITEMS - items_sent > LARGE_ROOM && $urandom_range(0, 11) == 0) begin
				n_first  = $urandom_range(30, 55);
				n_second = $urandom_range(10, 25);
			end else begin
				n_first  = $urandom_range(0, 9);
				n_second = $urandom_range(0, 9);
			end
			run_lists(n_first, n_second, $urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0)
				drain_rows();
		end

		// wind down: let every owed row arrive, then let the block settle
		@(negedge clk);
		start  <= 1'b0;
		waited = 0;
		while (book.pending_rows.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.pending_rows.size() > 0)
			book.report("rows never delivered", 0, book.pending_rows.size());

		$display("covered %0d requests and %0d finishes, %0d of them after a dropped key",
		         book.requests, book.finishes, book.overflow_finishes);
		$display("checked %0d sorted rows, %0d mismatches", book.rows_checked, book.errors);
		if (book.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
